### rtl/nts_pkg.sv
// Package: shared constants, types, tables and sequencing functions of the stop search.
`timescale 1ns / 1ps
package nts_pkg;

    localparam int MAX_STOPS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int IDX_W        = $clog2(MAX_STOPS);
    localparam int CNT_W        = $clog2(MAX_STOPS + 1);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int SLOT_W = 4;
    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int MIN_W  = 27;
    localparam int CFG_W  = 32;
    localparam int STOPS_W = 5;
    localparam int DEG_W  = 33;
    localparam int ANG_W  = 40;
    localparam int XY_W   = 36;

    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [XY_W-1:0]  t_xy;
    typedef t_ang t_atan_tab [CORDIC_STEPS];

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [31:0] RAD_M   = 32'((PI_Q60 >> 23) / 180);
    localparam t_ang        PI_ANG  = t_ang'(PI_Q60 >> 28);
    localparam t_ang        HALF_PI_ANG = t_ang'(PI_Q60 >> 29);
    localparam t_xy         CORDIC_K = 36'sd1304065748;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [MIN_W-1:0] MINUTES_MAX = '1;

    localparam logic [STOPS_W-1:0] STOPS_RESET = 5'd13;
    localparam logic [CFG_W-1:0]   MPR_RESET   = 32'd29579766;

    typedef enum logic [0:0] {
        CFG_STOPS_IN_USE = 1'b0,
        CFG_MINUTES_PER_RAD = 1'b1
    } t_cfg_reg;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_READ,
        OP_ROT_LAT1, OP_ROT_DLAT, OP_MUL_H1, OP_ROT_DLON, OP_MUL_H2,
        OP_ROT_LAT2, OP_MUL_CC, OP_MUL_TERM, OP_FORM_A,
        OP_SQRT_X, OP_SQRT_Y, OP_VEC, OP_MUL_MIN, OP_RANK, OP_NEXT, OP_PUBLISH
    } t_op;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} t_state;

    typedef enum logic [2:0] {CP_IDLE, CP_MUL, CP_SCALE, CP_REDUCE, CP_ITER} t_cord_ph;

    typedef struct packed {
        logic done;
        logic last;
        logic out_busy;
    } t_stat;

    // restoring long division, used only while building the angle table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q62 by its alternating series
    function automatic logic [63:0] atan_q62(int i);
        logic [63:0] sum;
        int e;
        int k;
        sum = '0;
        e = 62 - i;
        k = 0;
        if (i == 0) begin
            sum = PI_Q60;
        end else begin
            while (e >= 0) begin
                if (k[0]) sum = sum - udiv64(64'd1 << e, 64'(2 * k + 1));
                else      sum = sum + udiv64(64'd1 << e, 64'(2 * k + 1));
                e = e - 2 * i;
                k = k + 1;
            end
        end
        return sum;
    endfunction

    function automatic t_atan_tab atan_table();
        t_atan_tab t;
        for (int i = 0; i < CORDIC_STEPS; i++) t[i] = t_ang'(atan_q62(i) >> 30);
        return t;
    endfunction

    localparam t_atan_tab ATAN_TAB = atan_table();

    function automatic logic [63:0] mag64(input t_xy v);
        return v[XY_W-1] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic is_unit(input t_op op);
        return op inside {OP_ROT_LAT1, OP_ROT_DLAT, OP_ROT_DLON, OP_ROT_LAT2,
                          OP_MUL_H1, OP_MUL_H2, OP_MUL_CC, OP_MUL_TERM, OP_MUL_MIN,
                          OP_SQRT_X, OP_SQRT_Y, OP_VEC};
    endfunction

    function automatic t_op next_op(input t_op op, input logic last);
        case (op)
            OP_ROT_LAT1: return OP_READ;
            OP_READ:     return OP_ROT_DLAT;
            OP_ROT_DLAT: return OP_MUL_H1;
            OP_MUL_H1:   return OP_ROT_DLON;
            OP_ROT_DLON: return OP_MUL_H2;
            OP_MUL_H2:   return OP_ROT_LAT2;
            OP_ROT_LAT2: return OP_MUL_CC;
            OP_MUL_CC:   return OP_MUL_TERM;
            OP_MUL_TERM: return OP_FORM_A;
            OP_FORM_A:   return OP_SQRT_X;
            OP_SQRT_X:   return OP_SQRT_Y;
            OP_SQRT_Y:   return OP_VEC;
            OP_VEC:      return OP_MUL_MIN;
            OP_MUL_MIN:  return OP_RANK;
            OP_RANK:     return last ? OP_PUBLISH : OP_NEXT;
            OP_NEXT:     return OP_READ;
            default:     return OP_NONE;
        endcase
    endfunction

endpackage

### rtl/nts_in_if.sv
// Interface: input item channel (load or query).
`timescale 1ns / 1ps
interface nts_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [nts_pkg::SLOT_W-1:0]     stop_slot;
    logic signed [nts_pkg::LAT_W-1:0] latitude;
    logic signed [nts_pkg::LON_W-1:0] longitude;

    modport source (output valid, operation, stop_slot, latitude, longitude, input ready);
    modport sink (input valid, operation, stop_slot, latitude, longitude, output ready);
endinterface

### rtl/nts_out_if.sv
// Interface: result item channel (two nearest stops).
`timescale 1ns / 1ps
interface nts_out_if;
    logic                          valid;
    logic                          ready;
    logic [nts_pkg::SLOT_W-1:0]    nearest_index;
    logic [nts_pkg::MIN_W-1:0]     nearest_minutes;
    logic [nts_pkg::SLOT_W-1:0]    runner_up_index;
    logic [nts_pkg::MIN_W-1:0]     runner_up_minutes;

    modport source (output valid, nearest_index, nearest_minutes, runner_up_index,
                    runner_up_minutes, input ready);
    modport sink (input valid, nearest_index, nearest_minutes, runner_up_index,
                  runner_up_minutes, output ready);
endinterface

### rtl/nts_mul.sv
// Module: 64x64 unsigned multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
module nts_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    import nts_pkg::*;

    logic         r_busy, r_done;
    logic [2:0]   r_k;
    logic [1:0]   r_ppk;
    logic [63:0]  r_a, r_b, r_pp;
    logic [127:0] r_acc;
    logic [31:0]  w_ha, w_hb;
    logic [127:0] w_pp_sh;

    assign w_ha = r_k[1] ? r_a[63:32] : r_a[31:0];
    assign w_hb = r_k[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_ppk)
            2'd0:    w_pp_sh = 128'(r_pp);
            2'd3:    w_pp_sh = 128'(r_pp) << 64;
            default: w_pp_sh = 128'(r_pp) << 32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // multiply one pair, add the previous pair
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_k != 3'd4) begin
                r_pp  <= w_ha * w_hb;
                r_ppk <= r_k[1:0];
            end
            if (r_k != 3'd0) r_acc <= r_acc + w_pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/nts_cordic.sv
// Module: shared circular CORDIC, rotation from a degree count or vectoring from (x, y).
`timescale 1ns / 1ps
module nts_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_vec,
    input  logic                              i_half,
    input  logic signed [nts_pkg::DEG_W-1:0]  i_deg,
    input  logic [31:0]                       i_vx,
    input  logic [31:0]                       i_vy,
    output logic                              o_done,
    output nts_pkg::t_xy                      o_sin,
    output nts_pkg::t_xy                      o_cos,
    output nts_pkg::t_ang                     o_ang
);
    import nts_pkg::*;

    t_cord_ph            r_ph, n_ph;
    logic                r_done;
    logic [31:0]         r_mag;
    logic                r_neg, r_half, r_vec, r_flip;
    logic [63:0]         r_prod;
    logic [1:0]          r_red;
    logic [STEP_W-1:0]   r_i;
    t_ang                r_th;
    t_xy                 r_x, r_y;
    logic [31:0]         w_mag;
    logic [63:0]         w_sh;
    t_ang                w_scaled;
    logic                w_sigma, w_last;
    t_xy                 w_xs, w_ys;

    assign w_mag    = i_deg[DEG_W-1] ? 32'(-i_deg) : 32'(i_deg);
    assign w_sh     = r_half ? (r_prod >> 28) : (r_prod >> 27);
    assign w_scaled = t_ang'(w_sh[ANG_W-1:0]);
    assign w_last   = (r_i == STEP_W'(CORDIC_STEPS - 1));
    assign w_xs     = r_x >>> r_i;
    assign w_ys     = r_y >>> r_i;
    // rotation follows the angle sign, vectoring drives y toward zero
    assign w_sigma  = r_vec ? (r_y <= 0) : (r_th >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= CP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= (r_ph == CP_ITER) && w_last;
        end
    end

    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            CP_IDLE:   if (i_start) n_ph = i_vec ? CP_ITER : CP_MUL;
            CP_MUL:    n_ph = CP_SCALE;
            CP_SCALE:  n_ph = CP_REDUCE;
            CP_REDUCE: if (r_red == 2'd2) n_ph = CP_ITER;
            CP_ITER:   if (w_last) n_ph = CP_IDLE;
            default:   n_ph = CP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            CP_IDLE: begin
                if (i_start) begin
                    r_mag  <= w_mag;
                    r_neg  <= i_deg[DEG_W-1];
                    r_half <= i_half;
                    r_vec  <= i_vec;
                    r_i    <= '0;
                    r_red  <= '0;
                    r_flip <= 1'b0;
                    if (i_vec) begin
                        r_x  <= t_xy'({4'b0, i_vx});
                        r_y  <= t_xy'({4'b0, i_vy});
                        r_th <= '0;
                    end
                end
            end
            CP_MUL: r_prod <= r_mag * RAD_M;
            CP_SCALE: begin
                r_th <= r_neg ? -w_scaled : w_scaled;
                r_x  <= CORDIC_K;
                r_y  <= '0;
            end
            CP_REDUCE: begin
                r_red <= r_red + 2'd1;
                if (r_th > HALF_PI_ANG) begin
                    r_th   <= r_th - PI_ANG;
                    r_flip <= ~r_flip;
                end else if (r_th < -HALF_PI_ANG) begin
                    r_th   <= r_th + PI_ANG;
                    r_flip <= ~r_flip;
                end
            end
            CP_ITER: begin
                r_i <= r_i + STEP_W'(1);
                if (w_sigma) begin
                    r_x  <= r_x - w_ys;
                    r_y  <= r_y + w_xs;
                    r_th <= r_th - ATAN_TAB[r_i];
                end else begin
                    r_x  <= r_x + w_ys;
                    r_y  <= r_y - w_xs;
                    r_th <= r_th + ATAN_TAB[r_i];
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_ang  = r_th[ANG_W-1] ? '0 : r_th;
endmodule

### rtl/nts_datapath.sv
// Module: stop table, configuration, arithmetic units, ranking and result register.
`timescale 1ns / 1ps
module nts_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nts_pkg::t_op                      i_cmd,
    input  logic [nts_pkg::SLOT_W-1:0]        i_slot,
    input  logic signed [nts_pkg::LAT_W-1:0]  i_lat,
    input  logic signed [nts_pkg::LON_W-1:0]  i_lon,
    input  logic                              i_cfg_we,
    input  nts_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [nts_pkg::CFG_W-1:0]         i_cfg_data,
    output nts_pkg::t_stat                    o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [nts_pkg::SLOT_W-1:0]        o_nearest_index,
    output logic [nts_pkg::MIN_W-1:0]         o_nearest_minutes,
    output logic [nts_pkg::SLOT_W-1:0]        o_runner_up_index,
    output logic [nts_pkg::MIN_W-1:0]         o_runner_up_minutes
);
    import nts_pkg::*;

    logic signed [LAT_W-1:0] r_lat_mem [MAX_STOPS];
    logic signed [LON_W-1:0] r_lon_mem [MAX_STOPS];

    logic [STOPS_W-1:0]      r_stops;
    logic [CFG_W-1:0]        r_mpr;
    logic signed [LAT_W-1:0] r_lat1, r_lat2;
    logic signed [LON_W-1:0] r_lon1, r_lon2;
    logic [IDX_W-1:0]        r_idx, r_best_idx, r_next_idx;
    logic [MIN_W:0]          r_best_d, r_next_d;
    logic [MIN_W-1:0]        r_d;
    t_xy                     r_cos1;
    logic [63:0]             r_h1, r_h2, r_ccm, r_term, r_a;
    logic                    r_cc_neg;
    logic [31:0]             r_sx, r_sy;
    t_op                     r_pend;
    logic                    r_out_valid;

    logic [63:0]             r_sq_v, r_sq_res, r_sq_bit;
    logic [4:0]              r_sq_n;
    logic                    r_sq_busy, r_sq_done;

    logic                    w_cord_start, w_half, w_cord_done;
    logic signed [DEG_W-1:0] w_deg;
    t_xy                     w_sin, w_cos;
    t_ang                    w_ang;
    logic                    w_mul_start, w_mul_done;
    logic [63:0]             w_ma, w_mb;
    logic [127:0]            w_prod;
    logic [CNT_W-1:0]        w_n;
    logic [64:0]             w_sum, w_a;
    logic [63:0]             w_trial;
    logic [MIN_W:0]          w_d;

    always_comb begin
        w_cord_start = 1'b1;
        w_half = 1'b1;
        case (i_cmd)
            OP_ROT_LAT1: begin w_deg = DEG_W'(r_lat1); w_half = 1'b0; end
            OP_ROT_DLAT: w_deg = DEG_W'(r_lat1) - DEG_W'(r_lat2);
            OP_ROT_DLON: w_deg = DEG_W'(r_lon1) - DEG_W'(r_lon2);
            OP_ROT_LAT2: begin w_deg = DEG_W'(r_lat2); w_half = 1'b0; end
            OP_VEC:      w_deg = '0;
            default: begin
                w_deg = '0;
                w_cord_start = 1'b0;
            end
        endcase
    end

    nts_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_vec   (i_cmd == OP_VEC),
        .i_half  (w_half),
        .i_deg   (w_deg),
        .i_vx    (r_sx),
        .i_vy    (r_sy),
        .o_done  (w_cord_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos),
        .o_ang   (w_ang)
    );

    always_comb begin
        w_mul_start = 1'b1;
        case (i_cmd)
            OP_MUL_H1, OP_MUL_H2: begin w_ma = mag64(w_sin); w_mb = mag64(w_sin); end
            OP_MUL_CC:   begin w_ma = mag64(r_cos1); w_mb = mag64(w_cos); end
            OP_MUL_TERM: begin w_ma = r_ccm; w_mb = r_h2; end
            OP_MUL_MIN:  begin w_ma = 64'(w_ang) << 1; w_mb = 64'(r_mpr); end
            default: begin
                w_ma = '0;
                w_mb = '0;
                w_mul_start = 1'b0;
            end
        endcase
    end

    nts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // search length clamped to the table, and to at least two stops
    always_comb begin
        if (int'(r_stops) > MAX_STOPS) w_n = CNT_W'(MAX_STOPS);
        else if (r_stops < STOPS_W'(2)) w_n = CNT_W'(2);
        else w_n = CNT_W'(r_stops);
    end

    always_comb begin
        w_sum = 65'(r_h1) + 65'(r_term);
        if (!r_cc_neg) w_a = w_sum;
        else if (r_h1 > r_term) w_a = 65'(r_h1 - r_term);
        else w_a = '0;
        if (w_a > 65'(ONE_Q62)) w_a = 65'(ONE_Q62);
    end

    assign w_trial = r_sq_res + r_sq_bit;
    assign w_d = {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stops     <= STOPS_RESET;
            r_mpr       <= MPR_RESET;
            r_out_valid <= 1'b0;
            r_sq_busy   <= 1'b0;
            r_sq_done   <= 1'b0;
            r_sq_n      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STOPS_IN_USE:    r_stops <= i_cfg_data[STOPS_W-1:0];
                    CFG_MINUTES_PER_RAD: r_mpr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd == OP_PUBLISH) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            r_sq_done <= 1'b0;
            if (i_cmd == OP_SQRT_X || i_cmd == OP_SQRT_Y) begin
                r_sq_busy <= 1'b1;
                r_sq_n    <= '0;
            end else if (r_sq_busy) begin
                r_sq_n <= r_sq_n + 5'd1;
                if (r_sq_n == 5'd31) begin
                    r_sq_busy <= 1'b0;
                    r_sq_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == OP_LOAD && int'(i_slot) < MAX_STOPS) begin
            r_lat_mem[IDX_W'(i_slot)] <= i_lat;
            r_lon_mem[IDX_W'(i_slot)] <= i_lon;
        end
        if (i_cmd == OP_READ) begin
            r_lat2 <= r_lat_mem[r_idx];
            r_lon2 <= r_lon_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_unit(i_cmd)) r_pend <= i_cmd;
        case (i_cmd)
            OP_START: begin
                r_lat1   <= i_lat;
                r_lon1   <= i_lon;
                r_idx    <= '0;
                r_best_d <= '1;
                r_next_d <= '1;
            end
            OP_MUL_CC: r_cc_neg <= r_cos1[XY_W-1] ^ w_cos[XY_W-1];
            OP_FORM_A: r_a <= w_a[63:0];
            OP_SQRT_X: begin
                r_sq_v   <= ONE_Q62 - r_a;
                r_sq_res <= '0;
                r_sq_bit <= ONE_Q62;
            end
            OP_SQRT_Y: begin
                r_sq_v   <= r_a;
                r_sq_res <= '0;
                r_sq_bit <= ONE_Q62;
            end
            OP_RANK: begin
                // ties keep the earlier winner
                if (w_d < r_best_d) begin
                    r_next_d   <= r_best_d;
                    r_next_idx <= r_best_idx;
                    r_best_d   <= w_d;
                    r_best_idx <= r_idx;
                end else if (w_d < r_next_d) begin
                    r_next_d   <= w_d;
                    r_next_idx <= r_idx;
                end
            end
            OP_NEXT: r_idx <= r_idx + IDX_W'(1);
            OP_PUBLISH: begin
                o_nearest_index     <= SLOT_W'(r_best_idx);
                o_nearest_minutes   <= r_best_d[MIN_W-1:0];
                o_runner_up_index   <= SLOT_W'(r_next_idx);
                o_runner_up_minutes <= r_next_d[MIN_W-1:0];
            end
            default: ;
        endcase
        if (r_sq_busy) begin
            if (r_sq_v >= w_trial) begin
                r_sq_v   <= r_sq_v - w_trial;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (w_cord_done && r_pend == OP_ROT_LAT1) r_cos1 <= w_cos;
        if (r_sq_done) begin
            if (r_pend == OP_SQRT_X) r_sx <= r_sq_res[31:0];
            else r_sy <= r_sq_res[31:0];
        end
        if (w_mul_done) begin
            case (r_pend)
                OP_MUL_H1:   r_h1   <= w_prod[63:0];
                OP_MUL_H2:   r_h2   <= w_prod[63:0];
                OP_MUL_CC:   r_ccm  <= w_prod[63:0];
                OP_MUL_TERM: r_term <= w_prod[125:62];
                OP_MUL_MIN:  r_d    <= (w_prod[127:59] != '0) ? MINUTES_MAX : w_prod[58:32];
                default: ;
            endcase
        end
    end

    assign o_stat.done     = w_cord_done | w_mul_done | r_sq_done;
    assign o_stat.last     = (CNT_W'(r_idx) + CNT_W'(1)) == w_n;
    assign o_stat.out_busy = r_out_valid;
    assign o_out_valid     = r_out_valid;
endmodule

### rtl/nts_ctrl.sv
// Module: sequencer that steps the datapath through a load or a query.
`timescale 1ns / 1ps
module nts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    output nts_pkg::t_op    o_cmd,
    input  nts_pkg::t_stat  i_stat
);
    import nts_pkg::*;

    t_state r_state, n_state;
    t_op    r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op) begin
                        o_cmd   = OP_START;
                        n_state = ST_ISSUE;
                        n_step  = OP_ROT_LAT1;
                    end else begin
                        o_cmd = OP_LOAD;
                    end
                end
            end
            ST_ISSUE: begin
                // hold the result until the previous one is taken
                if (!(r_step == OP_PUBLISH && i_stat.out_busy)) begin
                    o_cmd = r_step;
                    if (is_unit(r_step)) n_state = ST_WAIT;
                    else if (r_step == OP_PUBLISH) n_state = ST_IDLE;
                    else n_step = next_op(r_step, i_stat.last);
                end
            end
            ST_WAIT: begin
                if (i_stat.done) begin
                    n_state = ST_ISSUE;
                    n_step  = next_op(r_step, i_stat.last);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

### rtl/nearest_two_stops_haversine_unit.sv
// Top level: nearest two stops by haversine distance, sequencer plus datapath.
//
//   channel  | dir | contents
//   in_ch    | in  | operation, stop_slot, latitude, longitude (load or query item)
//   out_ch   | out | nearest_index/minutes, runner_up_index/minutes (one item per query)
//   i_cfg_*  | in  | write enable, register index, 32-bit data
//
// A load item is written to the stop table as it is taken. A query first finds
// the point's cosine, then for each searched stop runs three CORDIC rotations,
// two square roots, one vectoring pass and five multiplies in series; the result
// shows in the cycle after the publish step.
// Reset is synchronous and active low; the stop table is not cleared.
// A finished result waits in the output register; a new item is taken meanwhile,
// but the next query result holds until the previous one is taken.
`timescale 1ns / 1ps
module nearest_two_stops_haversine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    nts_in_if.sink                       in_ch,
    nts_out_if.source                    out_ch,
    input  logic                         i_cfg_we,
    input  nts_pkg::t_cfg_reg            i_cfg_index,
    input  logic [nts_pkg::CFG_W-1:0]    i_cfg_data
);
    import nts_pkg::*;

    t_op   w_cmd;
    t_stat w_stat;

    nts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_op    (in_ch.operation),
        .o_in_ready (in_ch.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    nts_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_slot              (in_ch.stop_slot),
        .i_lat               (in_ch.latitude),
        .i_lon               (in_ch.longitude),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_stat              (w_stat),
        .i_out_ready         (out_ch.ready),
        .o_out_valid         (out_ch.valid),
        .o_nearest_index     (out_ch.nearest_index),
        .o_nearest_minutes   (out_ch.nearest_minutes),
        .o_runner_up_index   (out_ch.runner_up_index),
        .o_runner_up_minutes (out_ch.runner_up_minutes)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == OP_PUBLISH) |-> !w_stat.out_busy)
        else $error("result published over a pending item");

    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == OP_PUBLISH) |=> out_ch.valid)
        else $error("published result not shown");

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> (w_cmd == OP_NONE || w_cmd == OP_LOAD || w_cmd == OP_START))
        else $error("datapath step issued while taking input");
endmodule
